// ----- rtl/core/attention_score_softmax_defines.svh -----
// assertion macros shared by the checker
`ifndef ATTENTION_SCORE_SOFTMAX_DEFINES_SVH
`define ATTENTION_SCORE_SOFTMAX_DEFINES_SVH

// same-cycle implication
`define ATSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("attention_score_softmax check failed");

// next-cycle implication
`define ATSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("attention_score_softmax check failed");

`endif

// ----- rtl/core/atss_pkg.sv -----
// constants, codes and exp2 table for the attention score softmax block
`timescale 1ns / 1ps
package atss_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_DIM  = 16;

  localparam int ROW_IW   = $clog2(MAX_ROWS);
  localparam int DIM_IW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH    = MAX_ROWS * MAX_DIM;
  localparam int ADDR_W   = $clog2(DEPTH);

  localparam logic [17:0] LOG2E_Q16 = 18'd94548;

  typedef logic [1:0] action_t;
  localparam action_t ACT_LOAD_Q  = 2'd0;
  localparam action_t ACT_LOAD_K  = 2'd1;
  localparam action_t ACT_COMPUTE = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_DIM   = 2'd0;
  localparam reg_idx_t REG_ROWS  = 2'd1;
  localparam reg_idx_t REG_SCALE = 2'd2;

  localparam logic [4:0]  DIM_RST   = 5'd4;
  localparam logic [6:0]  ROWS_RST  = 7'd6;
  localparam logic [15:0] SCALE_RST = 16'd32768;

  // 2^(-i/16) in Q.16
  function automatic logic [16:0] exp2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/attention_score_softmax.sv -----
// Loads query and key elements one per cycle while the block is idle; a compute
// item walks every key row through one shared multiplier (dot product by read,
// multiply and accumulate steps per column, scale, then exp by read, difference,
// log2e, interpolate and value steps per row) and a one-bit-per-cycle divider for
// normalization that runs 34 steps per output weight; the block is stalled
// meanwhile. Loads and ignored items leave the block idle.
`timescale 1ns / 1ps
module attention_score_softmax (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  atss_pkg::action_t in_action,
  input  logic [5:0]  in_row_index,
  input  logic [3:0]  in_dim_index,
  input  logic signed [15:0] in_element_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_query_row,
  output logic [5:0]  out_key_row,
  output logic [15:0] out_weight,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import atss_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DOT_RD   = 15'b000000000000010,
    S_DOT_MUL  = 15'b000000000000100,
    S_DOT_ACC  = 15'b000000000001000,
    S_SCALE    = 15'b000000000010000,
    S_SCORE    = 15'b000000000100000,
    S_EXP_RD   = 15'b000000001000000,
    S_EXP_D    = 15'b000000010000000,
    S_EXP_T    = 15'b000000100000000,
    S_EXP_I    = 15'b000001000000000,
    S_EXP_V    = 15'b000010000000000,
    S_DIV_RD   = 15'b000100000000000,
    S_DIV_INIT = 15'b001000000000000,
    S_DIV_STEP = 15'b010000000000000,
    S_OUT      = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [4:0]  dim_r;
  logic [6:0]  rows_r;
  logic [15:0] scale_r;

  logic [15:0] q_mem [DEPTH];
  logic [15:0] k_mem [DEPTH];
  logic [31:0] s_mem [MAX_ROWS];
  logic signed [15:0] q_rd_r, k_rd_r;
  logic [31:0] s_rd_r;

  logic [ROW_IW-1:0] qrow_r, j_r, rlast_r;
  logic [DIM_IW-1:0] c_r, dlast_r;
  logic signed [35:0] acc_r;
  logic signed [54:0] mul_r;
  logic signed [31:0] max_r;
  logic [32:0] d_r;
  logic [3:0]  seg_r;
  logic [4:0]  k_r;
  logic        kbig_r;
  logic [22:0] sum_r;
  logic [33:0] dvd_r, quo_r;
  logic [23:0] rem_r;
  logic [5:0]  bit_r;
  logic        out_valid_r;
  logic [15:0] weight_r;
  logic        last_r;

  logic accept, ld_ok, cmp_ok, q_we, k_we, s_we;
  logic [ADDR_W-1:0] wr_addr, q_addr, k_addr;
  logic [31:0] s_wdata;
  logic signed [36:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [54:0] mul_p, rnd;
  logic signed [31:0] score_c;
  logic [4:0] dims_c;
  logic [6:0] rows_c;
  logic [3:0] seg_c;
  logic [15:0] diff_c;
  logic [27:0] rnd2;
  logic [16:0] v_c, e_c;
  logic [32:0] d_c;
  logic [23:0] rem_sh;
  logic [33:0] quo_c;
  logic        cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_DIM:   prdata = {27'd0, dim_r};
      REG_ROWS:  prdata = {25'd0, rows_r};
      REG_SCALE: prdata = {16'd0, scale_r};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r   <= DIM_RST;
      rows_r  <= ROWS_RST;
      scale_r <= SCALE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DIM:   dim_r   <= pwdata[4:0];
        REG_ROWS:  rows_r  <= pwdata[6:0];
        REG_SCALE: scale_r <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  // clamped sizes
  always_comb begin
    if (dim_r == 5'd0) dims_c = 5'd1;
    else if (int'(dim_r) > MAX_DIM) dims_c = 5'(MAX_DIM);
    else dims_c = dim_r;
    if (rows_r == 7'd0) rows_c = 7'd1;
    else if (int'(rows_r) > MAX_ROWS) rows_c = 7'(MAX_ROWS);
    else rows_c = rows_r;
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign ld_ok    = (int'(in_row_index) < MAX_ROWS) && (int'(in_dim_index) < MAX_DIM);
  assign cmp_ok   = (in_action == ACT_COMPUTE) && ({1'b0, in_row_index} < rows_c);
  assign q_we     = accept && (in_action == ACT_LOAD_Q) && ld_ok;
  assign k_we     = accept && (in_action == ACT_LOAD_K) && ld_ok;
  assign wr_addr  = ADDR_W'(ADDR_W'(ROW_IW'(in_row_index)) * ADDR_W'(MAX_DIM)
                    + ADDR_W'(in_dim_index));
  assign q_addr   = ADDR_W'(ADDR_W'(qrow_r) * ADDR_W'(MAX_DIM) + ADDR_W'(c_r));
  assign k_addr   = ADDR_W'(ADDR_W'(j_r) * ADDR_W'(MAX_DIM) + ADDR_W'(c_r));

  always_ff @(posedge clk) begin
    if (q_we) q_mem[wr_addr] <= in_element_value;
    q_rd_r <= q_mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (k_we) k_mem[wr_addr] <= in_element_value;
    k_rd_r <= k_mem[k_addr];
  end

  always_ff @(posedge clk) begin
    if (s_we) s_mem[j_r] <= s_wdata;
    s_rd_r <= s_mem[j_r];
  end

  // shared multiplier operand select
  assign seg_c  = mul_r[31:28];
  assign diff_c = 16'(exp2_tab({1'b0, seg_c}) - exp2_tab(5'({1'b0, seg_c}) + 5'd1));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_DOT_MUL: begin
        mul_a = 37'(q_rd_r);
        mul_b = 18'(k_rd_r);
      end
      S_SCALE: begin
        mul_a = 37'(acc_r);
        mul_b = $signed({2'b00, scale_r});
      end
      S_EXP_T: begin
        mul_a = $signed({4'd0, d_r});
        mul_b = $signed(LOG2E_Q16);
      end
      S_EXP_I: begin
        mul_a = $signed({21'd0, diff_c});
        mul_b = $signed({6'd0, mul_r[27:16]});
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign rnd     = mul_r + 55'sd8388608;
  assign score_c = $signed({rnd[54], rnd[54:24]});
  assign d_c     = {max_r[31], max_r} - {s_rd_r[31], s_rd_r};
  assign rnd2    = mul_r[27:0] + 28'd2048;
  assign v_c     = exp2_tab({1'b0, seg_r}) - {1'b0, rnd2[27:12]};
  assign e_c     = kbig_r ? 17'd0 : (v_c >> k_r);
  assign rem_sh  = {rem_r[22:0], dvd_r[33]};
  assign quo_c   = {quo_r[32:0], (rem_sh >= {1'b0, sum_r})};

  assign s_we    = (state_r == S_SCORE) || (state_r == S_EXP_V);
  assign s_wdata = (state_r == S_SCORE) ? score_c : {15'd0, e_c};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (accept && cmp_ok) state_nxt = S_DOT_RD;
      S_DOT_RD:   state_nxt = S_DOT_MUL;
      S_DOT_MUL:  state_nxt = S_DOT_ACC;
      S_DOT_ACC:  state_nxt = (c_r == dlast_r) ? S_SCALE : S_DOT_RD;
      S_SCALE:    state_nxt = S_SCORE;
      S_SCORE:    state_nxt = (j_r == rlast_r) ? S_EXP_RD : S_DOT_RD;
      S_EXP_RD:   state_nxt = S_EXP_D;
      S_EXP_D:    state_nxt = S_EXP_T;
      S_EXP_T:    state_nxt = S_EXP_I;
      S_EXP_I:    state_nxt = S_EXP_V;
      S_EXP_V:    state_nxt = (j_r == rlast_r) ? S_DIV_RD : S_EXP_RD;
      S_DIV_RD:   state_nxt = S_DIV_INIT;
      S_DIV_INIT: state_nxt = S_DIV_STEP;
      S_DIV_STEP: if (bit_r == 6'd33) state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) state_nxt = last_r ? S_IDLE : S_DIV_RD;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DIV_STEP && bit_r == 6'd33) out_valid_r <= 1'b1;
      else if (state_r == S_OUT && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        qrow_r  <= ROW_IW'(in_row_index);
        rlast_r <= ROW_IW'(rows_c - 7'd1);
        dlast_r <= DIM_IW'(dims_c - 5'd1);
        j_r     <= '0;
        c_r     <= '0;
        acc_r   <= '0;
        sum_r   <= '0;
      end
      S_DOT_MUL: mul_r <= mul_p;
      S_DOT_ACC: begin
        acc_r <= acc_r + $signed(mul_r[35:0]);
        c_r   <= c_r + DIM_IW'(1);
      end
      S_SCALE: mul_r <= mul_p;
      S_SCORE: begin
        if (j_r == '0 || score_c > max_r) max_r <= score_c;
        j_r   <= (j_r == rlast_r) ? '0 : j_r + ROW_IW'(1);
        c_r   <= '0;
        acc_r <= '0;
      end
      S_EXP_D: d_r <= d_c;
      S_EXP_T: mul_r <= mul_p;
      S_EXP_I: begin
        seg_r  <= seg_c;
        k_r    <= mul_r[36:32];
        kbig_r <= |mul_r[54:37];
        mul_r  <= mul_p;
      end
      S_EXP_V: begin
        sum_r <= sum_r + 23'(e_c);
        j_r   <= (j_r == rlast_r) ? '0 : j_r + ROW_IW'(1);
      end
      S_DIV_INIT: begin
        dvd_r <= {1'b0, s_rd_r[16:0], 16'd0} + 34'(sum_r[22:1]);
        rem_r <= '0;
        quo_r <= '0;
        bit_r <= '0;
      end
      S_DIV_STEP: begin
        if (rem_sh >= {1'b0, sum_r}) begin
          rem_r <= rem_sh - {1'b0, sum_r};
        end else begin
          rem_r <= rem_sh;
        end
        quo_r <= quo_c;
        dvd_r <= {dvd_r[32:0], 1'b0};
        bit_r <= bit_r + 6'd1;
      end
      S_OUT: begin
        if (!out_stall && !last_r) j_r <= j_r + ROW_IW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DIV_STEP && bit_r == 6'd33) begin
      weight_r <= (quo_c[33:16] != 18'd0) ? 16'hFFFF : quo_c[15:0];
      last_r   <= (j_r == rlast_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_query_row = 6'(qrow_r);
  assign out_key_row   = 6'(j_r);
  assign out_weight    = weight_r;
  assign out_last      = last_r;

endmodule

// ----- rtl/core/atss_chk.sv -----
// port-level checker for the attention score softmax block
`timescale 1ns / 1ps
`include "attention_score_softmax_defines.svh"
module atss_chk (
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_last
);

  `ATSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `ATSS_ASSERT_NOW(a_busy_on_out, out_valid, in_stall)
  `ATSS_ASSERT_NEXT(a_mid_row_busy, out_valid && !out_stall && !out_last, in_stall)
  `ATSS_ASSERT_NEXT(a_gap_after_item, out_valid && !out_stall, !out_valid)

endmodule

bind attention_score_softmax atss_chk u_atss_chk (.*);

// ----- tb/tb_attention_score_softmax.sv -----
// testbench for attention_score_softmax: load/compute stimulus checked against a softmax predictor
`timescale 1ns / 1ps
module tb_attention_score_softmax;
  import atss_pkg::*;

  localparam action_t ACT_IGNORED = 2'd3;

  typedef struct packed {
    logic [5:0]  qrow;
    logic [5:0]  krow;
    logic [15:0] weight;
    logic        last;
  } weight_t;

  typedef struct {
    action_t     act;
    logic [5:0]  row;
    logic [3:0]  col;
    logic [15:0] val;
    bit          typed;
  } stim_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  action_t in_action;
  logic [5:0] in_row_index;
  logic [3:0] in_dim_index;
  logic signed [15:0] in_element_value;
  logic out_valid, out_stall;
  logic [5:0] out_query_row, out_key_row;
  logic [15:0] out_weight;
  logic out_last;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  attention_score_softmax uut (.*);

  int unsigned pow2_frac [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
    46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

  logic signed [15:0] q_mem [DEPTH];
  logic signed [15:0] k_mem [DEPTH];
  bit q_written [DEPTH];
  bit k_written [DEPTH];
  int unsigned dims_reg, rows_reg, scale_reg;
  weight_t weights_due[$];
  int errors, n_items, n_weights, n_computes;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  task report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int unsigned clamp(input int unsigned v, input int unsigned hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // updates the store copies and queues the weights a compute yields
  task softmax_row(input action_t act, input int row, input int col,
                   input logic signed [15:0] val, input bit queue_it);
    int unsigned dims, rows, t, k, f, seg, r, v;
    longint acc, maxv, d, sum, w;
    int score [MAX_ROWS];
    longint e [MAX_ROWS];
    weight_t res;
    dims = clamp(dims_reg, MAX_DIM);
    rows = clamp(rows_reg, MAX_ROWS);
    if (act == ACT_LOAD_Q || act == ACT_LOAD_K) begin
      if (act == ACT_LOAD_Q) begin
        q_mem[row*MAX_DIM+col] = val;
        q_written[row*MAX_DIM+col] = 1;
      end else begin
        k_mem[row*MAX_DIM+col] = val;
        k_written[row*MAX_DIM+col] = 1;
      end
      return;
    end
    if (act != ACT_COMPUTE || row >= rows) return;
    n_computes++;
    for (int j = 0; j < rows; j++) begin
      acc = 0;
      for (int c = 0; c < dims; c++)
        acc += longint'(q_mem[row*MAX_DIM+c]) * longint'(k_mem[j*MAX_DIM+c]);
      score[j] = int'((acc * longint'(scale_reg) + (longint'(1) << 23)) >>> 24);
    end
    maxv = score[0];
    for (int j = 1; j < rows; j++)
      if (score[j] > maxv) maxv = score[j];
    sum = 0;
    for (int j = 0; j < rows; j++) begin
      d = maxv - score[j];
      t = (d * 94548) >> 16;
      k = t >> 16;
      f = t & 16'hffff;
      seg = f >> 12;
      r = f & 12'hfff;
      v = pow2_frac[seg] - (((pow2_frac[seg] - pow2_frac[seg+1]) * r + 2048) >> 12);
      e[j] = (k > 31) ? 0 : (v >> k);
      sum += e[j];
    end
    if (!queue_it) return;
    for (int j = 0; j < rows; j++) begin
      w = (e[j] * 65536 + sum / 2) / sum;
      if (w > 65535) w = 65535;
      res.qrow = row;
      res.krow = j;
      res.weight = w;
      res.last = (j == rows - 1);
      weights_due.push_back(res);
    end
  endtask

  task send(input action_t act, input int row, input int col, input logic [15:0] val,
            input bit queue_it);
    in_action <= act;
    in_row_index <= row;
    in_dim_index <= col;
    in_element_value <= val;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    n_items++;
    softmax_row(act, row, col, val, queue_it);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task write_reg(input reg_idx_t idx, input int unsigned value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 4 * idx;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_DIM:   dims_reg = value & 5'h1f;
      REG_ROWS:  rows_reg = value & 7'h7f;
      REG_SCALE: scale_reg = value & 16'hffff;
      default: ;
    endcase
  endtask

  task drain;
    in_valid <= 0;
    @(posedge clk);
    while (weights_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // compute with any missing operands loaded first
  task compute_row(input int row);
    int dims, rows;
    dims = clamp(dims_reg, MAX_DIM);
    rows = clamp(rows_reg, MAX_ROWS);
    for (int c = 0; c < dims; c++)
      if (!q_written[row*MAX_DIM+c]) send(ACT_LOAD_Q, row, c, $urandom, 1);
    for (int j = 0; j < rows; j++)
      for (int c = 0; c < dims; c++)
        if (!k_written[j*MAX_DIM+c]) send(ACT_LOAD_K, j, c, $urandom, 1);
    send(ACT_COMPUTE, row, $urandom, $urandom, 1);
  endtask

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return $urandom_range(0, 8191) - 4096;
      default: return $urandom;
    endcase
  endfunction

  task random_phase(input int unsigned d, input int unsigned r, input int unsigned s,
                    input int count);
    int rows, dims, pick;
    write_reg(REG_DIM, d);
    write_reg(REG_ROWS, r);
    write_reg(REG_SCALE, s);
    rows = clamp(rows_reg, MAX_ROWS);
    dims = clamp(dims_reg, MAX_DIM);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send($urandom_range(0, 1), $urandom_range(0, rows - 1),
             $urandom_range(0, dims - 1), rand_value(), 1);
      else if (pick < 62)
        send($urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 15),
             rand_value(), 1);
      else if (pick < 88 && (rows < 64 || i % 10 == 0))
        compute_row($urandom_range(0, rows - 1));
      else if (pick < 94 && rows < 64)
        send(ACT_COMPUTE, $urandom_range(rows, 63), $urandom, $urandom, 1);
      else
        send(ACT_IGNORED, $urandom, $urandom, $urandom, 1);
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (!rst_n)
      out_stall <= 0;
    else case ((n_weights / 40) % 3)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk) begin
    weight_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_weights++;
      if (weights_due.size() == 0) begin
        $display("unexpected weight q%0d k%0d", out_query_row, out_key_row);
        errors++;
      end else begin
        want = weights_due.pop_front();
        if (out_query_row !== want.qrow) report("query_row", out_query_row, want.qrow);
        if (out_key_row !== want.krow) report("key_row", out_key_row, want.krow);
        if (out_weight !== want.weight) report("weight", out_weight, want.weight);
        if (out_last !== want.last) report("last", out_last, want.last);
      end
    end
  end

  stim_t directed [12] = '{
    '{ACT_LOAD_Q, 6'd0, 4'd0, 16'h7fff, 0},
    '{ACT_LOAD_Q, 6'd1, 4'd0, 16'h8000, 0},
    '{ACT_LOAD_K, 6'd0, 4'd0, 16'h7fff, 0},
    '{ACT_LOAD_K, 6'd1, 4'd0, 16'h8000, 0},
    '{ACT_COMPUTE, 6'd0, 4'd0, 16'h0000, 1},
    '{ACT_COMPUTE, 6'd1, 4'd15, 16'hffff, 1},
    '{ACT_COMPUTE, 6'd2, 4'd0, 16'h0000, 0},
    '{ACT_COMPUTE, 6'd63, 4'd15, 16'hffff, 0},
    '{ACT_IGNORED, 6'd63, 4'd15, 16'hffff, 0},
    '{ACT_LOAD_Q, 6'd63, 4'd15, 16'h5a5a, 0},
    '{ACT_LOAD_K, 6'd63, 4'd15, 16'ha5a5, 0},
    '{ACT_LOAD_K, 6'd62, 4'd0, 16'h0000, 0}
  };

  initial begin
    weight_t res;
    rst_n = 0;
    in_valid = 0;
    in_action = ACT_LOAD_Q;
    in_row_index = 0;
    in_dim_index = 0;
    in_element_value = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    dims_reg = DIM_RST;
    rows_reg = ROWS_RST;
    scale_reg = SCALE_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // zero scale flattens every score, so each of two keys gets half
    write_reg(REG_DIM, 1);
    write_reg(REG_ROWS, 2);
    write_reg(REG_SCALE, 0);
    foreach (directed[i]) begin
      if (directed[i].typed)
        for (int j = 0; j < 2; j++) begin
          res.qrow = directed[i].row;
          res.krow = j;
          res.weight = 16'd32768;
          res.last = (j == 1);
          weights_due.push_back(res);
        end
      send(directed[i].act, directed[i].row, directed[i].col, directed[i].val,
           !directed[i].typed);
    end
    drain();

    random_phase(0, 0, 65535, 25);
    random_phase(4, 6, 32768, 40);
    random_phase(31, 4, 65535, 25);
    random_phase(16, 3, 16384, 30);
    random_phase(1, 127, 40000, 20);
    random_phase(1, 64, 65535, 10);
    for (int p = 0; p < 2; p++)
      random_phase($urandom_range(1, 8), $urandom_range(2, 8), $urandom, 30);

    drain();
    $display("%0d items sent, %0d computes, %0d weights checked", n_items, n_computes,
             n_weights);
    $display("covered clamped and extreme dims/rows/scale, ignored and out-of-range items");
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
